// ----- src/prr_pkg.sv -----
// Shared constants, codes and types of the pulse train replayer.
package prr_pkg;

  localparam int PRR_STORE_DEPTH = 2048;

  localparam int FUNC_W      = 3;
  localparam int DUR_W       = 16;
  localparam int REP_W       = 8;
  localparam int TICK_W      = 20;
  localparam int OUT_CNT_W   = 12;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 40;
  localparam int CFG_IDX_W   = 1;

  localparam logic [FUNC_W-1:0] FN_LOAD  = 3'd0;
  localparam logic [FUNC_W-1:0] FN_START = 3'd1;
  localparam logic [FUNC_W-1:0] FN_TICK  = 3'd2;
  localparam logic [FUNC_W-1:0] FN_ABORT = 3'd3;
  localparam logic [FUNC_W-1:0] FN_CLEAR = 3'd4;

  localparam logic [CFG_IDX_W-1:0] REG_REPEAT_TOTAL = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAP_TICKS    = 1'd1;

  localparam logic [REP_W-1:0]  RST_REPEAT_TOTAL = 8'd5;
  localparam logic [TICK_W-1:0] RST_GAP_TICKS    = 20'd500000;

  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_TRAIN = 2'd1;
  localparam logic [1:0] PH_GAP   = 2'd2;

  typedef struct packed {
    logic accept;
    logic fetch_done;
  } prr_cmd_t;

  typedef struct packed {
    logic need_fetch;
  } prr_stat_t;

endpackage

// ----- src/pulse_train_replayer_core.sv -----
// Top level of the pulse train replayer: controller, datapath and checks.
// The block stores up to STORE_DEPTH pulse durations and replays them as a train
// of alternating levels, starting high, one word of kind tick per microsecond,
// followed by a low gap, repeated repeat_total times (once when repeat_total is
// zero). Every input word yields exactly one output word. A word that begins a
// new pulse (a start, a tick that ends a duration, a tick that restarts the train)
// stalls the input while the next duration comes from the duration RAM, whose
// read data is registered. The RAM needs no clearing pass after reset: only
// entries below the fill count are ever read. Configuration is always accepted.
module pulse_train_replayer_core
  import prr_pkg::*;
#(
  parameter int STORE_DEPTH = PRR_STORE_DEPTH
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // [15:0] duration_us
  input  logic [FUNC_W-1:0]      in_tuser,   // [2:0] func
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // [0] pin_level, [1] busy_res, [9:2] repeat_number, [21:10] sample_number,
  // [33:22] stored_count, [34] load_refused, [39:35] zero
  output logic [OUT_TDATA_W-1:0] out_tdata,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [TICK_W-1:0]      cfg_data
);

  prr_cmd_t  cmd;
  prr_stat_t stat;

  assign cfg_ready = 1'b1;

  prr_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  prr_datapath #(
    .STORE_DEPTH(STORE_DEPTH)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_func   (in_tuser),
    .in_dur    (in_tdata),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_word  (out_tdata)
  );

  a_fetch_stalls_input: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.accept && stat.need_fetch) |=> !in_tready)
    else $error("Input was taken while a duration fetch was pending.");

  a_fetch_follows_accept: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.fetch_done |-> $past(cmd.accept && stat.need_fetch))
    else $error("Duration fetch completed without a request.");

  a_idle_output_low: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tdata[1]) |-> !out_tdata[0])
    else $error("Output level high while no replay runs.");

  a_valid_from_accept: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(cmd.accept))
    else $error("Output word appeared without an accepted input word.");

endmodule

// ----- src/prr_ram.sv -----
// Generic simple dual-port RAM with one write port and a registered read port.
module prr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- src/prr_ctrl.sv -----
// Controller: handshake, fetch wait state and output valid flag.
module prr_ctrl
  import prr_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_tvalid,
  output logic      in_tready,
  output logic      out_tvalid,
  input  logic      out_tready,
  input  prr_stat_t stat,
  output prr_cmd_t  cmd
);

  localparam logic S_IDLE  = 1'b0;
  localparam logic S_FETCH = 1'b1;

  logic state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;
  logic accept;

  assign in_tready  = (state_r == S_IDLE) && (!out_valid_r || out_tready);
  assign accept     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;

  always_comb begin
    state_nxt      = state_r;
    cmd.accept     = accept;
    cmd.fetch_done = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (accept && stat.need_fetch) begin
          state_nxt = S_FETCH;
        end
      end
      S_FETCH: begin
        cmd.fetch_done = 1'b1;
        state_nxt      = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ----- src/prr_datapath.sv -----
// Datapath: playback counters, configuration registers, duration RAM and output word.
module prr_datapath
  import prr_pkg::*;
#(
  parameter int STORE_DEPTH = PRR_STORE_DEPTH
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic [FUNC_W-1:0]      in_func,
  input  logic [DUR_W-1:0]       in_dur,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [TICK_W-1:0]      cfg_data,
  input  prr_cmd_t               cmd,
  output prr_stat_t              stat,
  output logic [OUT_TDATA_W-1:0] out_word
);

  localparam int CNT_W  = $clog2(STORE_DEPTH + 1);
  localparam int ADDR_W = $clog2(STORE_DEPTH);

  logic [1:0]        phase_r, phase_nxt;
  logic              level_r, level_nxt;
  logic [CNT_W-1:0]  idx_r, idx_nxt, idx_inc;
  logic [CNT_W-1:0]  fill_r, fill_nxt;
  logic [TICK_W-1:0] ticks_r, ticks_nxt, tick_dec;
  logic [REP_W-1:0]  rep_r, rep_nxt, rep_inc, total;
  logic [REP_W-1:0]  repeat_total_r;
  logic [TICK_W-1:0] gap_ticks_r;
  logic              refused;
  logic              wr_req;
  logic              fetch;
  logic              end_gap;
  logic [ADDR_W-1:0] fetch_addr;
  logic [DUR_W-1:0]  rd_data;
  logic [OUT_TDATA_W-1:0] out_word_r;

  always_comb begin
    phase_nxt  = phase_r;
    level_nxt  = level_r;
    idx_nxt    = idx_r;
    ticks_nxt  = ticks_r;
    rep_nxt    = rep_r;
    fill_nxt   = fill_r;
    refused    = 1'b0;
    wr_req     = 1'b0;
    fetch      = 1'b0;
    end_gap    = 1'b0;
    idx_inc    = idx_r + CNT_W'(1);
    fetch_addr = idx_inc[ADDR_W-1:0];
    tick_dec   = (ticks_r != '0) ? ticks_r - TICK_W'(1) : '0;
    rep_inc    = rep_r + REP_W'(1);
    total      = (repeat_total_r == '0) ? REP_W'(1) : repeat_total_r;
    case (in_func)
      FN_LOAD: begin
        if (phase_r == PH_IDLE) begin
          if (fill_r >= CNT_W'(STORE_DEPTH)) begin
            refused = 1'b1;
          end else begin
            wr_req   = 1'b1;
            fill_nxt = fill_r + CNT_W'(1);
          end
        end
      end
      FN_START: begin
        if (phase_r == PH_IDLE && fill_r != '0) begin
          rep_nxt    = '0;
          phase_nxt  = PH_TRAIN;
          idx_nxt    = '0;
          level_nxt  = 1'b1;
          fetch      = 1'b1;
          fetch_addr = '0;
        end
      end
      FN_TICK: begin
        if (phase_r == PH_TRAIN) begin
          ticks_nxt = tick_dec;
          if (tick_dec == '0) begin
            idx_nxt = idx_inc;
            if (idx_inc < fill_r) begin
              level_nxt = ~level_r;
              fetch     = 1'b1;
            end else begin
              level_nxt = 1'b0;
              phase_nxt = PH_GAP;
              ticks_nxt = gap_ticks_r;
              end_gap   = (gap_ticks_r == '0);
            end
          end
        end else if (phase_r == PH_GAP) begin
          ticks_nxt = tick_dec;
          end_gap   = (tick_dec == '0);
        end
      end
      FN_ABORT: begin
        phase_nxt = PH_IDLE;
        level_nxt = 1'b0;
        idx_nxt   = '0;
        ticks_nxt = '0;
        rep_nxt   = '0;
      end
      FN_CLEAR: begin
        phase_nxt = PH_IDLE;
        level_nxt = 1'b0;
        idx_nxt   = '0;
        ticks_nxt = '0;
        rep_nxt   = '0;
        fill_nxt  = '0;
      end
      default: begin
      end
    endcase
    if (end_gap) begin
      rep_nxt = rep_inc;
      if (rep_inc >= total) begin
        phase_nxt = PH_IDLE;
        level_nxt = 1'b0;
        idx_nxt   = '0;
        ticks_nxt = '0;
      end else begin
        phase_nxt  = PH_TRAIN;
        idx_nxt    = '0;
        level_nxt  = 1'b1;
        fetch      = 1'b1;
        fetch_addr = '0;
      end
    end
  end

  assign stat.need_fetch = fetch;

  prr_ram #(
    .WIDTH(DUR_W),
    .DEPTH(STORE_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (cmd.accept && wr_req),
    .wr_addr (fill_r[ADDR_W-1:0]),
    .wr_data (in_dur),
    .rd_en   (cmd.accept && fetch),
    .rd_addr (fetch_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= PH_IDLE;
      level_r        <= 1'b0;
      idx_r          <= '0;
      fill_r         <= '0;
      ticks_r        <= '0;
      rep_r          <= '0;
      repeat_total_r <= RST_REPEAT_TOTAL;
      gap_ticks_r    <= RST_GAP_TICKS;
    end else begin
      if (cmd.accept) begin
        phase_r <= phase_nxt;
        level_r <= level_nxt;
        idx_r   <= idx_nxt;
        fill_r  <= fill_nxt;
        ticks_r <= ticks_nxt;
        rep_r   <= rep_nxt;
      end else if (cmd.fetch_done) begin
        ticks_r <= (rd_data == '0) ? TICK_W'(1) : TICK_W'(rd_data);
      end
      if (cfg_we) begin
        if (cfg_index == REG_REPEAT_TOTAL) begin
          repeat_total_r <= cfg_data[REP_W-1:0];
        end else if (cfg_index == REG_GAP_TICKS) begin
          gap_ticks_r <= cfg_data;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      out_word_r <= {5'd0, refused, OUT_CNT_W'(fill_nxt), OUT_CNT_W'(idx_nxt), rep_nxt,
                     (phase_nxt != PH_IDLE), level_nxt};
    end
  end

  assign out_word = out_word_r;

endmodule
